// File: rtl/awu_pkg.sv
// ----------------------------------------------------------------------------
// Adam weight update engine package
// Shared constants, codes, types and a helper function of the engine.
// ----------------------------------------------------------------------------
package awu_pkg;

	localparam int NUM_WEIGHTS = 4096;
	localparam int IDX_W       = $clog2(NUM_WEIGHTS);

	localparam int OP_W      = 2;
	localparam int FIELD_W   = 12;
	localparam int DATA_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NAN   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_LIMIT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_LR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_B1P = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_B2P = 2'd2;

	localparam logic [31:0] LR_RESET  = 32'h3A83126F;
	localparam logic [31:0] B1P_RESET = 32'h3F666666;
	localparam logic [31:0] B2P_RESET = 32'h3F7FBE77;

	localparam logic [31:0] F_B1    = 32'h3F666666;
	localparam logic [31:0] F_B2    = 32'h3F7FBE77;
	localparam logic [31:0] F_C1    = 32'h3DCCCCD0;
	localparam logic [31:0] F_C2    = 32'h3A831200;
	localparam logic [31:0] F_EPS   = 32'h322BCC77;
	localparam logic [31:0] F_ONE   = 32'h3F800000;
	localparam logic [31:0] F_LIMIT = 32'h42FE0000;
	localparam logic [31:0] F_QNAN  = 32'h7FC00000;
	localparam logic [31:0] F_DNAN  = 32'hFFC00000;
	localparam logic [30:0] F_INF   = 31'h7F800000;

	localparam logic [2:0] FOP_ADD  = 3'd0;
	localparam logic [2:0] FOP_SUB  = 3'd1;
	localparam logic [2:0] FOP_MUL  = 3'd2;
	localparam logic [2:0] FOP_DIV  = 3'd3;
	localparam logic [2:0] FOP_SQRT = 3'd4;

	typedef struct packed {
		logic       start;
		logic [2:0] op;
	} fpu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] res;
	} fpu_rsp_t;

	function automatic logic f_is_nan(input logic [31:0] x);
		return x[30:0] > F_INF;
	endfunction

endpackage

// File: rtl/awu_if.sv
// ----------------------------------------------------------------------------
// Adam weight update engine channels
// Request, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface awu_in_if;
	import awu_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic [FIELD_W-1:0]   weight_index;
	logic [DATA_W-1:0]    operand_value;

	modport source(output valid, op, weight_index, operand_value, input ready);
	modport sink(input valid, op, weight_index, operand_value, output ready);
endinterface

interface awu_out_if;
	import awu_pkg::*;
	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   weight_value;
	logic [STATUS_W-1:0] status;

	modport source(output valid, weight_value, status, input ready);
	modport sink(input valid, weight_value, status, output ready);
endinterface

interface awu_cfg_if;
	import awu_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/awu_fpu.sv
// ----------------------------------------------------------------------------
// Shared single precision unit
// Add, subtract, multiply, divide and square root with round to nearest
// even, one operation at a time, with an iterative divider and root.
// ----------------------------------------------------------------------------
module awu_fpu (
	input  logic               clk,
	input  logic               arst_n,
	input  awu_pkg::fpu_req_t  req,
	input  logic [31:0]        a,
	input  logic [31:0]        b,
	output awu_pkg::fpu_rsp_t  rsp
);
	import awu_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ADD    = 4'd1;
	localparam logic [3:0] S_PREA   = 4'd2;
	localparam logic [3:0] S_PREB   = 4'd3;
	localparam logic [3:0] S_DIV    = 4'd4;
	localparam logic [3:0] S_SQADJ  = 4'd5;
	localparam logic [3:0] S_SQRT   = 4'd6;
	localparam logic [3:0] S_NORM   = 4'd7;
	localparam logic [3:0] S_DENORM = 4'd8;
	localparam logic [3:0] S_ROUND  = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	localparam logic [4:0] DIV_LAST  = 5'd25;
	localparam logic [4:0] SQRT_LAST = 5'd24;

	logic [3:0]         state_q;
	logic [2:0]         op_q;
	logic               sign_q;
	logic               effsub_q;
	logic [23:0]        ma_q;
	logic [23:0]        mb_q;
	logic signed [11:0] ea_q;
	logic signed [11:0] eb_q;
	logic [7:0]         d_q;
	logic [47:0]        sig_q;
	logic               stk_q;
	logic signed [11:0] ex_q;
	logic [25:0]        rem_q;
	logic [25:0]        quo_q;
	logic [24:0]        root_q;
	logic [49:0]        n_q;
	logic [4:0]         cnt_q;
	logic [31:0]        res_q;

	logic [31:0]        bx;
	logic               a_nan, a_inf, a_zero, b_nan, b_inf, b_zero, sx, a_ge;
	logic [23:0]        ma, mb;
	logic signed [11:0] eza, ezb, ediff;
	logic               spec_hit;
	logic [31:0]        spec_res;

	logic [47:0]        big48, sml48, shr, sum;
	logic               astk;
	logic [25:0]        ddiff;
	logic               dge;
	logic [27:0]        remx, trial, rnew;
	logic               sge;
	logic signed [11:0] eu, sh_full;
	logic               odd;
	logic [47:0]        lost_mask;
	logic [23:0]        mant;
	logic               rup;
	logic [11:0]        ex_m1;
	logic [35:0]        tot;

	always_comb begin
		bx = (req.op == FOP_SUB && !f_is_nan(b)) ? {~b[31], b[30:0]} : b;
		a_nan  = f_is_nan(a);
		b_nan  = f_is_nan(bx);
		a_inf  = a[30:0] == F_INF;
		b_inf  = bx[30:0] == F_INF;
		a_zero = a[30:0] == 31'd0;
		b_zero = bx[30:0] == 31'd0;
		sx     = a[31] ^ bx[31];
		ma     = {|a[30:23], a[22:0]};
		mb     = {|bx[30:23], bx[22:0]};
		eza    = (a[30:23] == 8'd0) ? 12'sd1 : $signed({4'b0, a[30:23]});
		ezb    = (bx[30:23] == 8'd0) ? 12'sd1 : $signed({4'b0, bx[30:23]});
		a_ge   = a[30:0] >= bx[30:0];
		ediff  = a_ge ? (eza - ezb) : (ezb - eza);
	end

	always_comb begin
		spec_hit = 1'b1;
		spec_res = 32'd0;
		case (req.op)
			FOP_ADD, FOP_SUB: begin
				if (a_nan) spec_res = a | 32'h00400000;
				else if (b_nan) spec_res = bx | 32'h00400000;
				else if (a_inf && b_inf && sx) spec_res = F_DNAN;
				else if (a_inf) spec_res = a;
				else if (b_inf) spec_res = bx;
				else if (a_zero && b_zero) spec_res = {a[31] & bx[31], 31'd0};
				else if (a_zero) spec_res = bx;
				else if (b_zero) spec_res = a;
				else spec_hit = 1'b0;
			end
			FOP_MUL: begin
				if (a_nan) spec_res = a | 32'h00400000;
				else if (b_nan) spec_res = bx | 32'h00400000;
				else if ((a_inf && b_zero) || (a_zero && b_inf)) spec_res = F_DNAN;
				else if (a_inf || b_inf) spec_res = {sx, F_INF};
				else if (a_zero || b_zero) spec_res = {sx, 31'd0};
				else spec_hit = 1'b0;
			end
			FOP_DIV: begin
				if (b_zero) spec_res = (a_zero || a_nan) ? F_QNAN : {sx, F_INF};
				else if (a_nan) spec_res = a | 32'h00400000;
				else if (b_nan) spec_res = bx | 32'h00400000;
				else if (a_inf && b_inf) spec_res = F_DNAN;
				else if (a_inf) spec_res = {sx, F_INF};
				else if (b_inf || a_zero) spec_res = {sx, 31'd0};
				else spec_hit = 1'b0;
			end
			FOP_SQRT: begin
				if (a_nan) spec_res = a | 32'h00400000;
				else if (a_zero) spec_res = a;
				else if (a[31]) spec_res = F_QNAN;
				else if (a_inf) spec_res = a;
				else spec_hit = 1'b0;
			end
			default: spec_hit = 1'b1;
		endcase
	end

	always_comb begin
		big48 = {1'b0, ma_q, 23'd0};
		sml48 = {1'b0, mb_q, 23'd0};
		if (d_q >= 8'd48) begin
			shr  = 48'd0;
			astk = |sml48;
		end else begin
			shr  = sml48 >> d_q[5:0];
			astk = |(sml48 & ~({48{1'b1}} << d_q[5:0]));
		end
		sum = effsub_q ? (big48 - shr - {47'd0, astk}) : (big48 + shr);

		dge   = rem_q >= {2'b0, mb_q};
		ddiff = dge ? (rem_q - {2'b0, mb_q}) : rem_q;

		remx  = {rem_q, n_q[49:48]};
		trial = {1'b0, root_q, 2'b01};
		sge   = remx >= trial;
		rnew  = sge ? (remx - trial) : remx;

		odd = ~ea_q[0];
		eu  = ea_q - 12'sd127 - (odd ? 12'sd1 : 12'sd0);

		sh_full   = 12'sd1 - ex_q;
		lost_mask = ~({48{1'b1}} << sh_full[5:0]);

		mant  = sig_q[47:24];
		rup   = sig_q[23] & ((|sig_q[22:0]) | stk_q | mant[0]);
		ex_m1 = ex_q - 12'sd1;
		tot   = ({24'd0, ex_m1} << 23) + {12'd0, mant} + {35'd0, rup};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= 5'd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.start) begin
						cnt_q <= 5'd0;
						if (spec_hit) state_q <= S_DONE;
						else if (req.op == FOP_MUL) state_q <= S_NORM;
						else if (req.op == FOP_DIV || req.op == FOP_SQRT) state_q <= S_PREA;
						else state_q <= S_ADD;
					end
				end
				S_ADD: state_q <= (sum == 48'd0 && !astk) ? S_DONE : S_NORM;
				S_PREA: begin
					if (ma_q[23]) state_q <= (op_q == FOP_DIV) ? S_PREB : S_SQADJ;
				end
				S_PREB: begin
					if (mb_q[23]) state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == DIV_LAST) state_q <= S_NORM;
				end
				S_SQADJ: state_q <= S_SQRT;
				S_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == SQRT_LAST) state_q <= S_NORM;
				end
				S_NORM: begin
					if (sig_q[47]) state_q <= S_DENORM;
				end
				S_DENORM: state_q <= S_ROUND;
				S_ROUND: state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q     <= req.op;
				sign_q   <= (req.op == FOP_ADD || req.op == FOP_SUB) ?
					(a_ge ? a[31] : bx[31]) : sx;
				effsub_q <= sx;
				stk_q    <= 1'b0;
				res_q    <= spec_res;
				if (req.op == FOP_ADD || req.op == FOP_SUB) begin
					ma_q   <= a_ge ? ma : mb;
					mb_q   <= a_ge ? mb : ma;
					ea_q   <= a_ge ? eza : ezb;
					d_q    <= ediff[7:0];
				end else begin
					ma_q <= ma;
					mb_q <= mb;
					ea_q <= eza;
					eb_q <= ezb;
				end
				sig_q <= {24'd0, ma} * {24'd0, mb};
				ex_q  <= eza + ezb - 12'sd126;
			end
			S_ADD: begin
				sig_q <= sum;
				stk_q <= astk;
				ex_q  <= ea_q + 12'sd1;
				res_q <= 32'd0;
			end
			S_PREA: begin
				if (!ma_q[23]) begin
					if (ma_q[23:8] == 16'd0) begin
						ma_q <= ma_q << 16;
						ea_q <= ea_q - 12'sd16;
					end else if (ma_q[23:16] == 8'd0) begin
						ma_q <= ma_q << 8;
						ea_q <= ea_q - 12'sd8;
					end else if (ma_q[23:20] == 4'd0) begin
						ma_q <= ma_q << 4;
						ea_q <= ea_q - 12'sd4;
					end else begin
						ma_q <= ma_q << 1;
						ea_q <= ea_q - 12'sd1;
					end
				end
			end
			S_PREB: begin
				rem_q <= {2'b0, ma_q};
				quo_q <= 26'd0;
				if (!mb_q[23]) begin
					if (mb_q[23:8] == 16'd0) begin
						mb_q <= mb_q << 16;
						eb_q <= eb_q - 12'sd16;
					end else if (mb_q[23:16] == 8'd0) begin
						mb_q <= mb_q << 8;
						eb_q <= eb_q - 12'sd8;
					end else if (mb_q[23:20] == 4'd0) begin
						mb_q <= mb_q << 4;
						eb_q <= eb_q - 12'sd4;
					end else begin
						mb_q <= mb_q << 1;
						eb_q <= eb_q - 12'sd1;
					end
				end
			end
			S_DIV: begin
				rem_q <= {ddiff[24:0], 1'b0};
				quo_q <= {quo_q[24:0], dge};
				sig_q <= {quo_q[24:0], dge, 22'd0};
				stk_q <= |ddiff;
				ex_q  <= ea_q - eb_q + 12'sd127;
			end
			S_SQADJ: begin
				n_q    <= odd ? {ma_q, 1'b0, 25'd0} : {1'b0, ma_q, 25'd0};
				ex_q   <= (eu >>> 1) + 12'sd127;
				rem_q  <= 26'd0;
				root_q <= 25'd0;
			end
			S_SQRT: begin
				rem_q  <= rnew[25:0];
				root_q <= {root_q[23:0], sge};
				n_q    <= {n_q[47:0], 2'b00};
				sig_q  <= {root_q[23:0], sge, 23'd0};
				stk_q  <= |rnew;
			end
			S_NORM: begin
				if (!sig_q[47]) begin
					if (sig_q[47:32] == 16'd0) begin
						sig_q <= sig_q << 16;
						ex_q  <= ex_q - 12'sd16;
					end else if (sig_q[47:40] == 8'd0) begin
						sig_q <= sig_q << 8;
						ex_q  <= ex_q - 12'sd8;
					end else if (sig_q[47:44] == 4'd0) begin
						sig_q <= sig_q << 4;
						ex_q  <= ex_q - 12'sd4;
					end else begin
						sig_q <= sig_q << 1;
						ex_q  <= ex_q - 12'sd1;
					end
				end
			end
			S_DENORM: begin
				if (ex_q < 12'sd1) begin
					ex_q <= 12'sd1;
					if (sh_full >= 12'sd48) begin
						sig_q <= 48'd0;
						stk_q <= stk_q | (|sig_q);
					end else begin
						sig_q <= sig_q >> sh_full[5:0];
						stk_q <= stk_q | (|(sig_q & lost_mask));
					end
				end
			end
			S_ROUND: begin
				if (tot >= 36'h07F800000) res_q <= {sign_q, F_INF};
				else res_q <= {sign_q, tot[30:0]};
			end
			default: ;
		endcase
	end

	assign rsp.done = (state_q == S_DONE);
	assign rsp.res  = res_q;

endmodule

// File: rtl/adam_weight_update_engine.sv
// ----------------------------------------------------------------------------
// Adam weight update engine
// Per-weight Adam optimiser step over single precision weight and moment
// stores, built around one shared floating point unit.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. A load or a read passes through a
// store read state, a fetch state and a write-back state after acceptance;
// an update runs sixteen floating point operations in turn through the one
// shared unit, among them three 26-step divisions and a 25-step square
// root. The result waits in an output register, and the next transaction
// may be accepted while it waits. Registers may be written at any time the
// engine is idle.
module adam_weight_update_engine (
	input logic         clk,
	input logic         arst_n,
	awu_in_if.sink      req,
	awu_out_if.source   rsp,
	awu_cfg_if.sink     cfg
);
	import awu_pkg::*;

	localparam logic [2:0] T_IDLE  = 3'd0;
	localparam logic [2:0] T_RD    = 3'd1;
	localparam logic [2:0] T_FETCH = 3'd2;
	localparam logic [2:0] T_ISSUE = 3'd3;
	localparam logic [2:0] T_WAIT  = 3'd4;
	localparam logic [2:0] T_WB    = 3'd5;

	localparam logic [3:0] U_M1  = 4'd0;
	localparam logic [3:0] U_G1  = 4'd1;
	localparam logic [3:0] U_MN  = 4'd2;
	localparam logic [3:0] U_V1  = 4'd3;
	localparam logic [3:0] U_G2  = 4'd4;
	localparam logic [3:0] U_G3  = 4'd5;
	localparam logic [3:0] U_VN  = 4'd6;
	localparam logic [3:0] U_D1  = 4'd7;
	localparam logic [3:0] U_HM  = 4'd8;
	localparam logic [3:0] U_D2  = 4'd9;
	localparam logic [3:0] U_HV  = 4'd10;
	localparam logic [3:0] U_SQ  = 4'd11;
	localparam logic [3:0] U_DEN = 4'd12;
	localparam logic [3:0] U_Q   = 4'd13;
	localparam logic [3:0] U_QL  = 4'd14;
	localparam logic [3:0] U_W   = 4'd15;

	localparam logic [2:0] D_T1 = 3'd0;
	localparam logic [2:0] D_T2 = 3'd1;
	localparam logic [2:0] D_M  = 3'd2;
	localparam logic [2:0] D_V  = 3'd3;
	localparam logic [2:0] D_HM = 3'd4;
	localparam logic [2:0] D_W  = 3'd5;

	logic [2:0]          st_q;
	logic [3:0]          step_q;
	logic [OP_W-1:0]     op_q;
	logic [IDX_W-1:0]    idx_q;
	logic [31:0]         g_q, w_q, m_q, v_q, t1_q, t2_q, hm_q;
	logic [31:0]         lr_q, b1p_q, b2p_q;
	logic                out_valid_q;
	logic [31:0]         out_w_q;
	logic [STATUS_W-1:0] out_st_q;

	logic [31:0] w_mem [NUM_WEIGHTS];
	logic [31:0] m_mem [NUM_WEIGHTS];
	logic [31:0] v_mem [NUM_WEIGHTS];
	logic [31:0] rd_w_q, rd_m_q, rd_v_q;

	logic                accept, wb_fire;
	logic [2:0]          fop, dest;
	logic [31:0]         fa, fb;
	logic [STATUS_W-1:0] status_d;
	fpu_req_t            fpu_req;
	fpu_rsp_t            fpu_rsp;

	assign accept    = req.valid && req.ready;
	assign req.ready = (st_q == T_IDLE);
	assign cfg.ready = 1'b1;
	assign wb_fire   = (st_q == T_WB) && (!out_valid_q || rsp.ready);

	always_comb begin
		fop  = FOP_MUL;
		fa   = F_B1;
		fb   = m_q;
		dest = D_T1;
		case (step_q)
			U_M1: begin fop = FOP_MUL; fa = F_B1; fb = m_q; dest = D_T1; end
			U_G1: begin fop = FOP_MUL; fa = F_C1; fb = g_q; dest = D_T2; end
			U_MN: begin fop = FOP_ADD; fa = t1_q; fb = t2_q; dest = D_M; end
			U_V1: begin fop = FOP_MUL; fa = F_B2; fb = v_q; dest = D_T1; end
			U_G2: begin fop = FOP_MUL; fa = F_C2; fb = g_q; dest = D_T2; end
			U_G3: begin fop = FOP_MUL; fa = t2_q; fb = g_q; dest = D_T2; end
			U_VN: begin fop = FOP_ADD; fa = t1_q; fb = t2_q; dest = D_V; end
			U_D1: begin fop = FOP_SUB; fa = F_ONE; fb = b1p_q; dest = D_T1; end
			U_HM: begin fop = FOP_DIV; fa = m_q; fb = t1_q; dest = D_HM; end
			U_D2: begin fop = FOP_SUB; fa = F_ONE; fb = b2p_q; dest = D_T1; end
			U_HV: begin fop = FOP_DIV; fa = v_q; fb = t1_q; dest = D_T2; end
			U_SQ: begin fop = FOP_SQRT; fa = t2_q; fb = t2_q; dest = D_T2; end
			U_DEN: begin fop = FOP_ADD; fa = t2_q; fb = F_EPS; dest = D_T1; end
			U_Q: begin fop = FOP_DIV; fa = hm_q; fb = t1_q; dest = D_T1; end
			U_QL: begin fop = FOP_MUL; fa = t1_q; fb = lr_q; dest = D_T1; end
			U_W: begin fop = FOP_SUB; fa = w_q; fb = t1_q; dest = D_W; end
			default: begin fop = FOP_MUL; fa = F_B1; fb = m_q; dest = D_T1; end
		endcase
	end

	assign fpu_req.start = (st_q == T_ISSUE);
	assign fpu_req.op    = fop;

	awu_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.a      (fa),
		.b      (fb),
		.rsp    (fpu_rsp)
	);

	always_comb begin
		if (f_is_nan(w_q) || f_is_nan(m_q) || f_is_nan(v_q)) status_d = STATUS_NAN;
		else if (w_q[30:0] >= F_LIMIT[30:0]) status_d = STATUS_LIMIT;
		else status_d = STATUS_OK;
	end

	always_ff @(posedge clk) begin
		if (wb_fire) begin
			w_mem[idx_q] <= w_q;
			m_mem[idx_q] <= m_q;
			v_mem[idx_q] <= v_q;
		end
		rd_w_q <= w_mem[idx_q];
		rd_m_q <= m_mem[idx_q];
		rd_v_q <= v_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= T_IDLE;
			step_q      <= U_M1;
			out_valid_q <= 1'b0;
			lr_q        <= LR_RESET;
			b1p_q       <= B1P_RESET;
			b2p_q       <= B2P_RESET;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_LR: lr_q <= cfg.data;
					CFG_B1P: b1p_q <= cfg.data;
					CFG_B2P: b2p_q <= cfg.data;
					default: ;
				endcase
			end
			if (wb_fire) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			case (st_q)
				T_IDLE: begin
					if (accept) st_q <= T_RD;
				end
				T_RD: st_q <= T_FETCH;
				T_FETCH: begin
					step_q <= U_M1;
					st_q   <= (op_q == OP_UPDATE) ? T_ISSUE : T_WB;
				end
				T_ISSUE: st_q <= T_WAIT;
				T_WAIT: begin
					if (fpu_rsp.done) begin
						if (step_q == U_W) begin
							st_q <= T_WB;
						end else begin
							step_q <= step_q + 4'd1;
							st_q   <= T_ISSUE;
						end
					end
				end
				T_WB: begin
					if (wb_fire) st_q <= T_IDLE;
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.op;
			idx_q <= req.weight_index[IDX_W-1:0];
			g_q   <= req.operand_value;
		end
		if (st_q == T_FETCH) begin
			if (op_q == OP_LOAD) begin
				w_q <= g_q;
				m_q <= 32'd0;
				v_q <= 32'd0;
			end else begin
				w_q <= rd_w_q;
				m_q <= rd_m_q;
				v_q <= rd_v_q;
			end
		end
		if (st_q == T_WAIT && fpu_rsp.done) begin
			case (dest)
				D_T1: t1_q <= fpu_rsp.res;
				D_T2: t2_q <= fpu_rsp.res;
				D_M: m_q <= fpu_rsp.res;
				D_V: v_q <= fpu_rsp.res;
				D_HM: hm_q <= fpu_rsp.res;
				D_W: w_q <= fpu_rsp.res;
				default: ;
			endcase
		end
		if (wb_fire) begin
			out_w_q  <= w_q;
			out_st_q <= status_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.weight_value = out_w_q;
	assign rsp.status       = out_st_q;

	a_fpu_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		fpu_rsp.done |-> st_q == T_WAIT)
		else $error("Floating point unit finished outside its wait state.");

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> st_q == T_RD)
		else $error("Accepted transaction did not start a store read.");

	a_result_after_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(st_q) == T_WB)
		else $error("Result appeared without a write-back.");

	a_load_takes_operand: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == T_FETCH && op_q == OP_LOAD) |=> w_q == $past(g_q))
		else $error("Load did not take the operand as the weight.");

endmodule

// File: sim/adam_weight_update_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adam weight update engine checker
// Watches the request, result and register channels, predicts each result
// with an independent single precision model and compares field by field.
// ----------------------------------------------------------------------------
module adam_weight_update_checker (
	input  logic clk,
	input  logic arst_n,
	awu_in_if    req,
	awu_out_if   rsp,
	awu_cfg_if   cfg,
	output int   failures,
	output int   pending
);
	import awu_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0]   weight;
		logic [STATUS_W-1:0] status;
	} weight_result_t;

	logic [31:0] step_scale;
	logic [31:0] b1_power;
	logic [31:0] b2_power;

	logic [31:0] weights [NUM_WEIGHTS];
	logic [31:0] moments1 [NUM_WEIGHTS];
	logic [31:0] moments2 [NUM_WEIGHTS];

	weight_result_t expected_weights[$];

	function automatic logic nan_bits(input logic [31:0] a);
		return a[30:0] > 31'h7F800000;
	endfunction

	function automatic logic inf_bits(input logic [31:0] a);
		return a[30:0] == 31'h7F800000;
	endfunction

	function automatic void fp_unpack(input logic [31:0] a, output logic [127:0] m,
			output int x);
		if (a[30:23] == 8'd0) begin
			m = 128'(a[22:0]);
			x = -149;
		end else begin
			m = 128'({1'b1, a[22:0]});
			x = int'(a[30:23]) - 150;
		end
	endfunction

	// Rounds sign * mag * 2^x to nearest even, subnormals and overflow included.
	function automatic logic [31:0] fp_round(input logic s, input logic [127:0] mag,
			input int x);
		int p;
		int e;
		int sh;
		logic [127:0] sig;
		logic [63:0] pk;
		logic g;
		logic st;
		p = 127;
		while (!mag[p])
			p--;
		if (p > 63) begin
			sh = p - 63;
			sig = mag >> sh;
			st = (mag & ((128'd1 << sh) - 128'd1)) != 0;
		end else begin
			sig = mag << (63 - p);
			st = 1'b0;
		end
		e = x + p + 127;
		if (e < 1) begin
			sh = 1 - e;
			if (sh > 64) begin
				st = st | (sig != 0);
				sig = '0;
			end else begin
				st = st | ((sig & ((128'd1 << sh) - 128'd1)) != 0);
				sig = sig >> sh;
			end
			e = 1;
		end
		pk = (64'(e - 1) << 23) + 64'(sig[63:40]);
		g = sig[39];
		st = st | (sig[38:0] != 0);
		if (g && (st || pk[0]))
			pk = pk + 64'd1;
		if (pk >= 64'h7F800000)
			return {s, 31'h7F800000};
		return {s, pk[30:0]};
	endfunction

	function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
		logic [127:0] ma;
		logic [127:0] mb;
		logic [127:0] ml;
		logic [127:0] ms;
		logic [127:0] mag;
		int xa;
		int xb;
		int xl;
		int d;
		logic sl;
		logic ss;
		logic s;
		if (nan_bits(a))
			return a | 32'h00400000;
		if (nan_bits(b))
			return b | 32'h00400000;
		if (inf_bits(a) && inf_bits(b))
			return (a[31] != b[31]) ? F_DNAN : a;
		if (inf_bits(a))
			return a;
		if (inf_bits(b))
			return b;
		if (a[30:0] == 0 && b[30:0] == 0)
			return {a[31] & b[31], 31'd0};
		if (a[30:0] == 0)
			return b;
		if (b[30:0] == 0)
			return a;
		fp_unpack(a, ma, xa);
		fp_unpack(b, mb, xb);
		if (xa >= xb) begin
			ml = ma; ms = mb; xl = xa; d = xa - xb; sl = a[31]; ss = b[31];
		end else begin
			ml = mb; ms = ma; xl = xb; d = xb - xa; sl = b[31]; ss = a[31];
		end
		ml = ml << 64;
		if (d <= 64)
			ms = ms << (64 - d);
		else
			ms = 128'd1;
		if (sl == ss) begin
			mag = ml + ms;
			s = sl;
		end else if (ml >= ms) begin
			mag = ml - ms;
			s = sl;
		end else begin
			mag = ms - ml;
			s = ss;
		end
		if (mag == 0)
			return 32'd0;
		return fp_round(s, mag, xl - 64);
	endfunction

	function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
		if (!nan_bits(a) && nan_bits(b))
			return b | 32'h00400000;
		return fp_add(a, {~b[31], b[30:0]});
	endfunction

	function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
		logic [127:0] ma;
		logic [127:0] mb;
		int xa;
		int xb;
		logic s;
		s = a[31] ^ b[31];
		if (nan_bits(a))
			return a | 32'h00400000;
		if (nan_bits(b))
			return b | 32'h00400000;
		if (inf_bits(a) || inf_bits(b)) begin
			if (a[30:0] == 0 || b[30:0] == 0)
				return F_DNAN;
			return {s, 31'h7F800000};
		end
		if (a[30:0] == 0 || b[30:0] == 0)
			return {s, 31'd0};
		fp_unpack(a, ma, xa);
		fp_unpack(b, mb, xb);
		return fp_round(s, ma * mb, xa + xb);
	endfunction

	function automatic logic [31:0] fp_div(input logic [31:0] a, input logic [31:0] b);
		logic [127:0] ma;
		logic [127:0] mb;
		logic [127:0] q;
		logic [127:0] r;
		int xa;
		int xb;
		logic s;
		s = a[31] ^ b[31];
		if (nan_bits(a))
			return a | 32'h00400000;
		if (nan_bits(b))
			return b | 32'h00400000;
		if (inf_bits(a) && inf_bits(b))
			return F_DNAN;
		if (inf_bits(a))
			return {s, 31'h7F800000};
		if (inf_bits(b))
			return {s, 31'd0};
		if (a[30:0] == 0 && b[30:0] == 0)
			return F_DNAN;
		if (b[30:0] == 0)
			return {s, 31'h7F800000};
		if (a[30:0] == 0)
			return {s, 31'd0};
		fp_unpack(a, ma, xa);
		fp_unpack(b, mb, xb);
		q = (ma << 100) / mb;
		r = (ma << 100) % mb;
		return fp_round(s, (q << 1) | 128'(r != 0), xa - xb - 101);
	endfunction

	// Division that yields the positive default NaN or a signed infinity on a zero divisor.
	function automatic logic [31:0] guarded_div(input logic [31:0] a, input logic [31:0] b);
		if (b[30:0] == 0) begin
			if (a[30:0] == 0 || nan_bits(a))
				return F_QNAN;
			return {a[31] ^ b[31], 31'h7F800000};
		end
		return fp_div(a, b);
	endfunction

	function automatic logic [31:0] fp_sqrt(input logic [31:0] a);
		logic [127:0] m;
		logic [127:0] rem;
		logic [127:0] res;
		logic [127:0] bitv;
		int x;
		if (nan_bits(a))
			return a | 32'h00400000;
		if (a[30:0] == 0)
			return a;
		if (a[31])
			return F_QNAN;
		if (inf_bits(a))
			return a;
		fp_unpack(a, m, x);
		if (x % 2 != 0) begin
			m = m << 1;
			x = x - 1;
		end
		rem = m << 100;
		res = '0;
		bitv = 128'd1 << 126;
		while (bitv != 0) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return fp_round(1'b0, (res << 1) | 128'(rem != 0), (x - 100) / 2 - 1);
	endfunction

	function automatic logic [STATUS_W-1:0] entry_health(input int idx);
		if (nan_bits(weights[idx]) || nan_bits(moments1[idx]) || nan_bits(moments2[idx]))
			return STATUS_NAN;
		if (weights[idx][30:0] >= F_LIMIT[30:0])
			return STATUS_LIMIT;
		return STATUS_OK;
	endfunction

	function automatic weight_result_t compute_adam_step(input logic [OP_W-1:0] op,
			input logic [FIELD_W-1:0] index, input logic [31:0] value);
		int idx;
		logic [31:0] m;
		logic [31:0] v;
		logic [31:0] t1;
		logic [31:0] t2;
		logic [31:0] hm;
		logic [31:0] hv;
		logic [31:0] den;
		logic [31:0] q;
		weight_result_t r;
		idx = int'(index) % NUM_WEIGHTS;
		if (op == OP_LOAD) begin
			weights[idx] = value;
			moments1[idx] = '0;
			moments2[idx] = '0;
		end else if (op == OP_UPDATE) begin
			t1 = fp_mul(F_B1, moments1[idx]);
			t2 = fp_mul(F_C1, value);
			m = fp_add(t1, t2);
			t1 = fp_mul(F_B2, moments2[idx]);
			t2 = fp_mul(F_C2, value);
			t2 = fp_mul(t2, value);
			v = fp_add(t1, t2);
			hm = guarded_div(m, fp_sub(F_ONE, b1_power));
			hv = guarded_div(v, fp_sub(F_ONE, b2_power));
			den = fp_add(fp_sqrt(hv), F_EPS);
			q = guarded_div(hm, den);
			q = fp_mul(q, step_scale);
			moments1[idx] = m;
			moments2[idx] = v;
			weights[idx] = fp_sub(weights[idx], q);
		end
		r.weight = weights[idx];
		r.status = entry_health(idx);
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
		failures++;
	endtask

	assign pending = expected_weights.size();

	initial
		failures = 0;

	always @(posedge clk or negedge arst_n) begin
		weight_result_t w;
		if (!arst_n) begin
			step_scale <= LR_RESET;
			b1_power <= B1P_RESET;
			b2_power <= B2P_RESET;
			expected_weights.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_LR: step_scale <= cfg.data;
					CFG_B1P: b1_power <= cfg.data;
					CFG_B2P: b2_power <= cfg.data;
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_weights.size() == 0) begin
					report("unexpected result transaction", rsp.weight_value, 32'd0);
				end else begin
					w = expected_weights.pop_front();
					if (rsp.weight_value !== w.weight)
						report("weight_value", rsp.weight_value, w.weight);
					if (rsp.status !== w.status)
						report("status", 32'(rsp.status), 32'(w.status));
				end
			end
			if (req.valid && req.ready)
				expected_weights = {expected_weights,
					compute_adam_step(req.op, req.weight_index, req.operand_value)};
		end
	end

endmodule

// File: sim/adam_weight_update_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adam weight update engine testbench
// Drives directed and random load, update, read and unused-code transactions through
// several register settings with random idling on both channels; a checker
// beside the engine predicts and compares every result.
// ----------------------------------------------------------------------------
module adam_weight_update_engine_test;
	import awu_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 85;

	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	logic clk;
	logic arst_n;
	int   failures;
	int   pending;
	int   cycles;
	logic smooth;
	int   ready_hold;

	logic loaded [NUM_WEIGHTS];
	int   pool[$];

	awu_in_if  req_ch();
	awu_out_if rsp_ch();
	awu_cfg_if cfg_ch();

	adam_weight_update_engine uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	adam_weight_update_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg      (cfg_ch),
		.failures (failures),
		.pending  (pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (smooth || r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (!rsp_ch.ready || smooth) begin
			rsp_ch.ready <= 1'b1;
			ready_hold <= $urandom_range(0, 30);
		end else begin
			rsp_ch.ready <= 1'b0;
			ready_hold <= gap_length();
		end
	end

	function automatic logic [31:0] pick_float();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return $urandom;
		if (r < 15)
			return {1'($urandom), 31'h7F800000};
		if (r < 18)
			return {1'($urandom), 31'd0};
		if (r < 21)
			return {1'($urandom), 8'd0, 23'($urandom)};
		if (r < 23)
			return {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
		return {1'($urandom), 8'($urandom_range(100, 134)), 23'($urandom)};
	endfunction

	task automatic send_item(input logic [OP_W-1:0] op, input int idx,
			input logic [31:0] value);
		int gap;
		gap = gap_length();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.weight_index <= FIELD_W'(idx);
		req_ch.operand_value <= value;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (op == OP_LOAD && !loaded[idx]) begin
			loaded[idx] = 1'b1;
			pool = {pool, idx};
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_item();
		int r;
		int idx;
		r = $urandom_range(0, 99);
		if (r < 15 || pool.size() < 4) begin
			if (pool.size() > 0 && $urandom_range(0, 2) == 0)
				idx = pool[$urandom_range(0, pool.size() - 1)];
			else if (pool.size() < 40)
				idx = $urandom_range(0, NUM_WEIGHTS - 1);
			else
				idx = pool[$urandom_range(0, pool.size() - 1)];
			send_item(OP_LOAD, idx, pick_float());
		end else begin
			idx = pool[$urandom_range(0, pool.size() - 1)];
			if (r < 82)
				send_item(OP_UPDATE, idx, pick_float());
			else if (r < 92)
				send_item(OP_READ, idx, $urandom);
			else
				send_item(OP_SPARE, idx, $urandom);
		end
	endtask

	initial begin
		cycles = 0;
		smooth = 1'b0;
		ready_hold = 0;
		foreach (loaded[i])
			loaded[i] = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_LOAD;
		req_ch.weight_index = '0;
		req_ch.operand_value = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_LR;
		cfg_ch.data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_LOAD, 0, 32'h00000000);
		send_item(OP_LOAD, NUM_WEIGHTS - 1, 32'hFFFFFFFF);
		send_item(OP_LOAD, 1, F_LIMIT);
		send_item(OP_LOAD, 2, 32'h42FDFFFF);
		send_item(OP_LOAD, 3, 32'hFF800000);
		send_item(OP_LOAD, 4, 32'h80000001);
		send_item(OP_READ, NUM_WEIGHTS - 1, 32'hFFFFFFFF);
		send_item(OP_SPARE, 1, 32'h00000000);
		send_item(OP_UPDATE, 0, 32'h00000000);
		send_item(OP_UPDATE, 0, 32'h7F7FFFFF);
		send_item(OP_UPDATE, 2, 32'h7F800000);
		send_item(OP_UPDATE, 2, 32'hFF800000);
		send_item(OP_UPDATE, 4, 32'h00000001);
		send_item(OP_UPDATE, 4, 32'h80000000);
		send_item(OP_UPDATE, 3, 32'h3F800000);
		send_item(OP_UPDATE, 1, 32'hFFC12345);
		send_item(OP_UPDATE, NUM_WEIGHTS - 1, 32'h3DCCCCCD);
		send_item(OP_LOAD, 2, 32'hC2FE0001);
		send_item(OP_UPDATE, 2, 32'hBF000000);
		send_item(OP_READ, 2, 32'hFFFFFFFF);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_LR, 32'h3C23D70A);
					write_reg(CFG_B1P, 32'h3E4CCCCD);
					write_reg(CFG_B2P, 32'h3F7D70A4);
				end
				1: begin
					write_reg(CFG_LR, 32'hFFFFFFFF);
					write_reg(CFG_B1P, F_ONE);
					write_reg(CFG_B2P, 32'h00000000);
				end
				2: begin
					write_reg(CFG_LR, 32'h00000000);
					write_reg(CFG_B1P, 32'hFFFFFFFF);
					write_reg(CFG_B2P, F_ONE);
				end
				3: begin
					write_reg(CFG_LR, 32'h7F7FFFFF);
					write_reg(CFG_B1P, 32'h80000000);
					write_reg(CFG_B2P, $urandom);
				end
				4: begin
					write_reg(CFG_LR, $urandom);
					write_reg(CFG_B1P, $urandom);
					write_reg(CFG_B2P, 32'h3F800001);
				end
				default: begin
					write_reg(CFG_LR, LR_RESET);
					write_reg(CFG_B1P, B1P_RESET);
					write_reg(CFG_B2P, B2P_RESET);
				end
			endcase
			smooth = (ph == 2);
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_item();
			drain();
		end

		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
